@@ hdl/bsda_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded stack package
// Item types, command codes and status codes shared by the stack block.
// ----------------------------------------------------------------------------
package bsda_pkg;

  localparam int unsigned CmdW      = 3;
  localparam int unsigned DataW     = 32;
  localparam int unsigned PosW      = 8;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned EntryCntW = 4;

  // Command codes; codes five to seven are ignored
  localparam logic [CmdW-1:0] CMD_PUSH   = 3'd0;
  localparam logic [CmdW-1:0] CMD_POP    = 3'd1;
  localparam logic [CmdW-1:0] CMD_PEEK   = 3'd2;
  localparam logic [CmdW-1:0] CMD_CHANGE = 3'd3;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 3'd4;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] data_word;
    logic [PosW-1:0]  position;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0]     read_word;
    logic [StatusW-1:0]   status;
    logic [EntryCntW-1:0] entry_count;
    logic                 is_full;
    logic                 is_empty;
  } out_item_t;

endpackage

@@ hdl/bsda_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack entry memory
// One write port and one read port; read data registered, valid in the cycle after the read.
// ----------------------------------------------------------------------------
module bsda_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/bounded_stack_with_depth_access_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded stack with depth access
// LIFO stack of words with push, pop, peek and change by depth, and clear.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | to block  | in_valid_i / in_stall_o | in_item_i  (bsda_pkg::in_item_t)
//  out     | from blk  | out_valid_o / out_stall_i | out_item_o (bsda_pkg::out_item_t)
//
//  One item is accepted per cycle while in_stall_o is low; every item gives one
//  result item, via stage 1 and then the result register. The count, flags and
//  status are decided at acceptance; the memory write (push, change) and read
//  (peek) go to the entry RAM on that edge; the peek word joins as stage 1 advances.
//  Reset clears the count and both pipeline stages; entry contents are left
//  as they are and are never read before being written.
//  A stalled output holds the result register; the stage behind it then
//  holds too and in_stall_o rises until the result is taken.
//
module bounded_stack_with_depth_access_top #(
  parameter int unsigned STACK_DEPTH = 8,
  parameter int unsigned WORD_WIDTH  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bsda_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bsda_pkg::out_item_t out_item_o
);

  import bsda_pkg::*;

  // Stored word width: words keep the low min(WORD_WIDTH, 32) bits of the 32-bit field
  localparam int unsigned StoreW = (WORD_WIDTH < DataW) ? WORD_WIDTH : DataW;
  localparam int unsigned AddrW  = $clog2(STACK_DEPTH);
  localparam int unsigned CntW   = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CmpW   = (CntW > PosW) ? CntW : PosW;
  localparam logic [CntW-1:0] FullCnt = CntW'(STACK_DEPTH);

  // Count of stored entries
  logic [CntW-1:0] cnt_q, cnt_d;

  // Stage 1: decided result fields waiting for the RAM read
  logic      pend_valid_q;
  out_item_t pend_q, pend_d;
  logic      pend_rd_q;

  // Stage 2: result register
  logic      out_valid_q;
  out_item_t out_item_q;

  logic in_acc, pend_adv, out_acc;

  // Decode signals
  logic [CmpW-1:0]  pos_ext, cnt_ext, diff;
  logic             pos_ok, is_full_now, is_empty_now;
  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [StoreW-1:0] rd_data;
  logic [StatusW-1:0] status;

  assign out_acc  = out_valid_q && !out_stall_i;
  assign pend_adv = pend_valid_q && (!out_valid_q || !out_stall_i);
  // Take a new item unless stage 1 is blocked behind a stalled result
  assign in_stall_o = pend_valid_q && !pend_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pos_ext      = CmpW'(in_item_i.position);
  assign cnt_ext      = CmpW'(cnt_q);
  assign diff         = cnt_ext - pos_ext;
  assign pos_ok       = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign is_full_now  = (cnt_q == FullCnt);
  assign is_empty_now = (cnt_q == '0);

  always_comb begin
    cnt_d   = cnt_q;
    status  = ST_OK;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    wr_addr = diff[AddrW-1:0];
    rd_addr = diff[AddrW-1:0];
    unique case (in_item_i.cmd)
      CMD_PUSH: begin
        wr_addr = cnt_q[AddrW-1:0];
        if (is_full_now) begin
          status = ST_FULL;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      CMD_POP: begin
        if (is_empty_now) begin
          status = ST_EMPTY;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      CMD_PEEK: begin
        // Empty takes precedence over a bad position
        if (is_empty_now) begin
          status = ST_EMPTY;
        end else if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      CMD_CHANGE: begin
        if (!pos_ok) begin
          status = ST_RANGE;
        end else begin
          wr_en = 1'b1;
        end
      end
      CMD_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pend_d             = '0;
    pend_d.status      = status;
    pend_d.entry_count = EntryCntW'(cnt_d);
    pend_d.is_full     = (cnt_d == FullCnt);
    pend_d.is_empty    = (cnt_d == '0);
  end

  bsda_ram #(
    .DEPTH(STACK_DEPTH),
    .WIDTH(StoreW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (in_acc && wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_item_i.data_word[StoreW-1:0]),
    .rd_en_i   (in_acc && rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Control: count and stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        cnt_q <= cnt_d;
      end
      if (in_acc) begin
        pend_valid_q <= 1'b1;
      end else if (pend_adv) begin
        pend_valid_q <= 1'b0;
      end
      if (pend_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: advance decided fields, merge the peek word on the way out
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_q    <= pend_d;
      pend_rd_q <= in_acc && rd_en;
    end
    if (pend_adv) begin
      out_item_q <= pend_q;
      if (pend_rd_q) begin
        out_item_q.read_word <= DataW'(rd_data);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Count never passes the stack depth
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("stack count above depth");

  // An accepted item always lands in stage 1
  a_acc_to_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> pend_valid_q)
    else $error("accepted item lost before stage 1");

  // A stalled result blocks stage 1 from overwriting it
  a_hold_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && pend_valid_q) |-> in_stall_o)
    else $error("stage 1 not held behind stalled result");

  // A refused push reports a full stack
  a_full_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status == ST_FULL) |-> out_item_q.is_full)
    else $error("full status without full flag");

  // Only a successful peek carries a nonzero word
  a_word_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.read_word != '0) |-> out_item_q.status == ST_OK)
    else $error("read word on failed command");

endmodule

@@ tb/tb_bounded_stack_with_depth_access_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded stack with depth access - self-checking testbench
// Drives push, pop, peek, change, clear and unused command items through the
// stack. Directed corner cases come first, then random traffic under three
// idling profiles, with a long output hold-off. Results are compared field by
// field against an in-order prediction of the stack contents.
// ----------------------------------------------------------------------------
module tb_bounded_stack_with_depth_access_top;
  import bsda_pkg::*;

  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned WORD_WIDTH  = 32;

  // Unused command codes: the block must ignore them
  localparam logic [CmdW-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CmdW-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CmdW-1:0] CMD_RSVD_7 = 3'd7;

  // Cycles of forced output stall, and the no-progress watchdog limit
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned STUCK_LIMIT = 2000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  bounded_stack_with_depth_access_top #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Command items waiting to be offered, and results owed by the block
  in_item_t    cmd_q[$];
  out_item_t   resp_fifo[$];

  // Shadow copy of the stack, advanced once per accepted command item
  logic [WORD_WIDTH-1:0] stack_words [STACK_DEPTH];
  int unsigned           stack_top = 0;

  // Idling percentages and hold-off requests, changed only on falling edges
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;

  int unsigned err_cnt   = 0;
  int unsigned stuck_cnt = 0;
  out_item_t   want_resp;

  // --------------------------------------------------------------------------
  // Stack behavior: apply one command to the shadow stack, return its result.
  // Peek on an empty stack reports empty before looking at the position; a
  // change on an empty stack is simply out of range.
  // --------------------------------------------------------------------------
  function automatic out_item_t lifo_exec(in_item_t it);
    out_item_t   r;
    logic        pos_ok;
    int unsigned idx;
    r      = '0;
    r.status = ST_OK;
    pos_ok = (it.position >= 1) && (it.position <= stack_top);
    idx    = pos_ok ? (stack_top - it.position) : 0;
    case (it.cmd)
      CMD_PUSH: begin
        if (stack_top >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_words[stack_top] = it.data_word;
          stack_top++;
        end
      end
      CMD_POP: begin
        if (stack_top == 0) r.status = ST_EMPTY;
        else stack_top--;
      end
      CMD_PEEK: begin
        if (stack_top == 0) r.status = ST_EMPTY;
        else if (!pos_ok) r.status = ST_RANGE;
        else r.read_word = stack_words[idx];
      end
      CMD_CHANGE: begin
        if (!pos_ok) r.status = ST_RANGE;
        else stack_words[idx] = it.data_word;
      end
      CMD_CLEAR: begin
        stack_top = 0;
      end
      default: begin
      end
    endcase
    r.entry_count = stack_top[EntryCntW-1:0];
    r.is_full     = (stack_top == STACK_DEPTH);
    r.is_empty    = (stack_top == 0);
    return r;
  endfunction

  // Random command with content; push_pct steers toward filling or draining.
  // Positions mostly land near the live depth, now and then anywhere.
  function automatic in_item_t rand_cmd(int unsigned push_pct);
    in_item_t    it;
    int unsigned roll;
    it.data_word = $urandom();
    it.position  = ($urandom_range(7) == 0) ? PosW'($urandom_range(255))
                                            : PosW'($urandom_range(9));
    if ($urandom_range(99) < push_pct) begin
      it.cmd = CMD_PUSH;
    end else begin
      roll = $urandom_range(19);
      if (roll < 6) it.cmd = CMD_POP;
      else if (roll < 12) it.cmd = CMD_PEEK;
      else if (roll < 17) it.cmd = CMD_CHANGE;
      else if (roll == 17) it.cmd = CMD_CLEAR;
      else if (roll == 18) it.cmd = $urandom_range(1) ? CMD_RSVD_5 : CMD_RSVD_6;
      else it.cmd = CMD_RSVD_7;
    end
    return it;
  endfunction

  task automatic add_cmd(input logic [CmdW-1:0] c, input logic [DataW-1:0] d,
                         input logic [PosW-1:0] p);
    in_item_t it;
    it.cmd       = c;
    it.data_word = d;
    it.position  = p;
    cmd_q.push_back(it);
  endtask

  // Queue n random items in bursts of 16 that alternate filling and draining
  task automatic add_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      cmd_q.push_back(rand_cmd(((i / 16) % 2 == 0) ? 70 : 25));
    end
  endtask

  // Hold the sender until every queued item has gone and every result is back
  task automatic wait_drain();
    while (cmd_q.size() != 0 || in_valid_i || resp_fifo.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic check_field(input string fname, input logic [DataW-1:0] exp_v,
                             input logic [DataW-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", fname, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: predict on acceptance, then offer the next item unless the sender
  // idles this cycle. A stalled item stays on the bus untouched.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        resp_fifo.push_back(lifo_exec(in_item_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i <= 1'b1;
          in_item_i  <= cmd_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each taken result against the oldest prediction, then pick
  // the stall for the next cycle. A hold-off request forces a long stall.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (resp_fifo.size() == 0) begin
          $error("result with no command outstanding: %p", out_item_o);
          err_cnt++;
        end else begin
          want_resp = resp_fifo.pop_front();
          check_field("read_word", want_resp.read_word, out_item_o.read_word);
          check_field("status", DataW'(want_resp.status), DataW'(out_item_o.status));
          check_field("entry_count", DataW'(want_resp.entry_count),
                      DataW'(out_item_o.entry_count));
          check_field("is_full", DataW'(want_resp.is_full), DataW'(out_item_o.is_full));
          check_field("is_empty", DataW'(want_resp.is_empty),
                      DataW'(out_item_o.is_empty));
        end
      end
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= STUCK_LIMIT) begin
      $display("tb_bounded_stack_with_depth_access_top: FAIL");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed corners, then random phases.
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Sender idles lightly, receiver heavily
    tx_idle_pct = 11;
    rx_idle_pct = 50;

    // Empty stack: pop, peek (position checked after emptiness), change
    add_cmd(CMD_POP, '0, 8'd1);
    add_cmd(CMD_PEEK, '0, 8'd1);
    add_cmd(CMD_PEEK, '0, 8'd0);
    add_cmd(CMD_CHANGE, 32'hDEAD_BEEF, 8'd1);
    // Extreme words, then reads at and past the live depth
    add_cmd(CMD_PUSH, 32'h0000_0000, 8'd0);
    add_cmd(CMD_PUSH, 32'hFFFF_FFFF, 8'd255);
    add_cmd(CMD_PEEK, '0, 8'd1);
    add_cmd(CMD_PEEK, '0, 8'd3);
    add_cmd(CMD_CHANGE, 32'hA5A5_A5A5, 8'd2);
    add_cmd(CMD_PEEK, '0, 8'd2);
    // Fill to the top, then try one more
    for (int i = 0; i < STACK_DEPTH - 2; i++) begin
      add_cmd(CMD_PUSH, $urandom(), PosW'($urandom_range(255)));
    end
    add_cmd(CMD_PUSH, 32'h1234_5678, 8'd1);
    add_cmd(CMD_PEEK, '0, 8'd8);
    add_cmd(CMD_PEEK, '0, 8'd255);
    add_cmd(CMD_CHANGE, 32'h5A5A_5A5A, 8'd9);
    // Unused codes leave the stack alone
    add_cmd(CMD_RSVD_5, 32'hFFFF_FFFF, 8'd1);
    add_cmd(CMD_RSVD_6, 32'hFFFF_FFFF, 8'd1);
    add_cmd(CMD_RSVD_7, 32'hFFFF_FFFF, 8'd1);
    add_cmd(CMD_POP, '0, 8'd0);
    // Clear twice: the second one hits an empty stack
    add_cmd(CMD_CLEAR, '0, 8'd0);
    add_cmd(CMD_CLEAR, '0, 8'd0);
    wait_drain();

    add_random(300);
    wait_drain();

    // Swap the idling profiles
    tx_idle_pct = 50;
    rx_idle_pct = 11;
    add_random(300);
    wait_drain();

    // No idling; stall the output for a long stretch while items keep coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests++;
    add_random(40);
    wait_drain();

    add_random(160);
    wait_drain();

    // Let the pipeline settle so stray results still get caught
    repeat (8) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_bounded_stack_with_depth_access_top: PASS");
    end else begin
      $display("tb_bounded_stack_with_depth_access_top: FAIL");
    end
    $finish;
  end

endmodule
